// File: sv/basic_program_detokenizer_assert.svh
// assertion macros for the basic program detokenizer
`ifndef BASIC_PROGRAM_DETOKENIZER_ASSERT_SVH
`define BASIC_PROGRAM_DETOKENIZER_ASSERT_SVH

// implication checked on every edge outside reset
`define BPD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define BPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/bpd_pkg.sv
// package: types, constants and keyword rom for the detokenizer
`timescale 1ns / 1ps
`default_nettype none
package bpd_pkg;

  localparam logic [7:0] NumMarkA   = 8'h0E;
  localparam logic [7:0] NumMarkB   = 8'h7E;
  localparam logic [7:0] KwFirst    = 8'hA3;
  localparam logic [7:0] NewlineTok = 8'h0D;
  localparam logic [7:0] DotChar    = 8'h2E;
  localparam logic [7:0] SpaceChar  = 8'h20;
  localparam logic [7:0] ZeroChar   = 8'h30;
  localparam int unsigned KwMaxLen  = 9;
  localparam int unsigned KwCount   = 93;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       has_char;
    logic       line_end;
    logic       stream_end;
    logic       truncated;
    logic       run_last;
  } out_item_t;

  typedef logic [KwMaxLen*8-1:0] kw_text_t;

  function automatic kw_text_t kw_pad(input string s);
    kw_text_t r;
    r = '0;
    for (int i = 0; i < s.len(); i++) begin
      r[i*8 +: 8] = s[i];
    end
    return r;
  endfunction

  // keyword text, first character in the low byte, zero padded
  function automatic kw_text_t kw_text(input logic [6:0] idx);
    kw_text_t r;
    unique case (idx)
      7'd0:  r = kw_pad("SPECTRUM");   7'd1:  r = kw_pad("PLAY");
      7'd2:  r = kw_pad("RND");        7'd3:  r = kw_pad("INKEY$");
      7'd4:  r = kw_pad("PI");         7'd5:  r = kw_pad("FN");
      7'd6:  r = kw_pad("POINT");      7'd7:  r = kw_pad("SCREEN$");
      7'd8:  r = kw_pad("ATTR");       7'd9:  r = kw_pad("AT");
      7'd10: r = kw_pad("TAB");        7'd11: r = kw_pad("VAL$");
      7'd12: r = kw_pad("CODE");       7'd13: r = kw_pad("VAL");
      7'd14: r = kw_pad("LEN");        7'd15: r = kw_pad("SIN");
      7'd16: r = kw_pad("COS");        7'd17: r = kw_pad("TAN");
      7'd18: r = kw_pad("ASN");        7'd19: r = kw_pad("ACS");
      7'd20: r = kw_pad("ATN");        7'd21: r = kw_pad("LN");
      7'd22: r = kw_pad("EXP");        7'd23: r = kw_pad("INT");
      7'd24: r = kw_pad("SQR");        7'd25: r = kw_pad("SGN");
      7'd26: r = kw_pad("ABS");        7'd27: r = kw_pad("PEEK");
      7'd28: r = kw_pad("IN");         7'd29: r = kw_pad("USR");
      7'd30: r = kw_pad("STR$");       7'd31: r = kw_pad("CHR$");
      7'd32: r = kw_pad("NOT");        7'd33: r = kw_pad("BIN");
      7'd34: r = kw_pad("OR");         7'd35: r = kw_pad("AND");
      7'd36: r = kw_pad("<=");         7'd37: r = kw_pad(">=");
      7'd38: r = kw_pad("<>");         7'd39: r = kw_pad("LINE");
      7'd40: r = kw_pad("THEN");       7'd41: r = kw_pad("TO");
      7'd42: r = kw_pad("STEP");       7'd43: r = kw_pad("DEF FN");
      7'd44: r = kw_pad("CAT");        7'd45: r = kw_pad("FORMAT");
      7'd46: r = kw_pad("MOVE");       7'd47: r = kw_pad("ERASE");
      7'd48: r = kw_pad("OPEN #");     7'd49: r = kw_pad("CLOSE #");
      7'd50: r = kw_pad("MERGE");      7'd51: r = kw_pad("VERIFY");
      7'd52: r = kw_pad("BEEP");       7'd53: r = kw_pad("CIRCLE");
      7'd54: r = kw_pad("INK");        7'd55: r = kw_pad("PAPER");
      7'd56: r = kw_pad("FLASH");      7'd57: r = kw_pad("BRIGHT");
      7'd58: r = kw_pad("INVERSE");    7'd59: r = kw_pad("OVER");
      7'd60: r = kw_pad("OUT");        7'd61: r = kw_pad("LPRINT");
      7'd62: r = kw_pad("LLIST");      7'd63: r = kw_pad("STOP");
      7'd64: r = kw_pad("READ");       7'd65: r = kw_pad("DATA");
      7'd66: r = kw_pad("RESTORE");    7'd67: r = kw_pad("NEW");
      7'd68: r = kw_pad("BORDER");     7'd69: r = kw_pad("CONTINUE");
      7'd70: r = kw_pad("DIM");        7'd71: r = kw_pad("REM");
      7'd72: r = kw_pad("FOR");        7'd73: r = kw_pad("GO TO");
      7'd74: r = kw_pad("GO SUB");     7'd75: r = kw_pad("INPUT");
      7'd76: r = kw_pad("LOAD");       7'd77: r = kw_pad("LIST");
      7'd78: r = kw_pad("LET");        7'd79: r = kw_pad("PAUSE");
      7'd80: r = kw_pad("NEXT");       7'd81: r = kw_pad("POKE");
      7'd82: r = kw_pad("PRINT");      7'd83: r = kw_pad("PLOT");
      7'd84: r = kw_pad("RUN");        7'd85: r = kw_pad("SAVE");
      7'd86: r = kw_pad("RANDOMIZE");  7'd87: r = kw_pad("IF");
      7'd88: r = kw_pad("CLS");        7'd89: r = kw_pad("DRAW");
      7'd90: r = kw_pad("CLEAR");      7'd91: r = kw_pad("RETURN");
      7'd92: r = kw_pad("COPY");
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/bpd_stream_if.sv
// valid/ready channel interface carrying one item
`timescale 1ns / 1ps
`default_nettype none
interface bpd_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/bpd_digits.sv
// line number to decimal digits by repeated subtraction of powers of ten
`timescale 1ns / 1ps
`default_nettype none
module bpd_digits
  import bpd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [15:0] value_i,
  output logic             done_o,
  output logic [19:0]      digits_o
);

  logic [15:0] rem_q, rem_d;
  logic [2:0]  pos_q, pos_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [19:0] dig_q, dig_d;
  logic        busy_q, busy_d;
  logic [15:0] pow;
  logic        ge;

  always_comb begin
    unique case (pos_q)
      3'd0: pow = 16'd10000;
      3'd1: pow = 16'd1000;
      3'd2: pow = 16'd100;
      3'd3: pow = 16'd10;
      default: pow = 16'd1;
    endcase
  end

  assign ge = rem_q >= pow;

  always_comb begin
    rem_d  = rem_q;
    pos_d  = pos_q;
    cnt_d  = cnt_q;
    dig_d  = dig_q;
    busy_d = busy_q;
    done_o = 1'b0;
    if (start_i) begin
      rem_d  = value_i;
      pos_d  = 3'd0;
      cnt_d  = 4'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - pow;
        cnt_d = cnt_q + 4'd1;
      end else begin
        dig_d[19 - 4*pos_q -: 4] = cnt_q;
        cnt_d = 4'd0;
        if (pos_q == 3'd4) begin
          busy_d = 1'b0;
          done_o = 1'b1;
        end else begin
          pos_d = pos_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      pos_q  <= pos_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dig_q <= dig_d;
  end

  assign digits_o = dig_q;

endmodule
`default_nettype wire

// File: sv/basic_program_detokenizer.sv
// top level of the basic program detokenizer
// Usage:
//   in_if carries program bytes (byte_in, last_in); out_if carries listing
//   items (char_out, has_char, line_end, stream_end, truncated, run_last).
//   One input item is taken when the block is idle; it is then busy until all
//   items it causes have been taken. Each output item sits in one output
//   register until the receiver is ready. The fourth header byte runs the
//   digit unit (one subtract-compare per cycle) and then gives up to six
//   characters, plus a line end if the line is empty. A keyword byte gives up
//   to ten characters, one per cycle from the keyword rom while the receiver
//   is ready. A stalled receiver holds the output register and the sequencer.
//   run_last marks the final item of each input byte; a byte with no item
//   completes silently. The last_in byte is followed by a stream end item
//   whose truncated flag tells if it fell inside a line; the header, line and
//   skip state then return to reset. Reset clears all control state at once.
`timescale 1ns / 1ps
`default_nettype none
`include "basic_program_detokenizer_assert.svh"
module basic_program_detokenizer
  import bpd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bpd_stream_if.sink   in_if,
  bpd_stream_if.source out_if
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIGITS, ST_NUM, ST_KW, ST_LE, ST_SE
  } state_e;

  state_e      state_q;
  logic [2:0]  hpos_q;
  logic [15:0] line_q;
  logic [15:0] left_q;
  logic [2:0]  skip_q;
  logic        space_q;
  logic        last_q;
  logic [3:0]  idx_q;
  logic        lead_q;
  logic [6:0]  kw_q;
  logic        ovalid_q;
  out_item_t   odata_q;

  logic        dstart, ddone;
  logic [19:0] digits;
  kw_text_t    kw;
  logic [7:0]  kwch;
  logic        kwend;
  logic [3:0]  nd;
  logic        ofree;
  logic        oload;
  logic [7:0]  b;

  assign b      = in_if.data.byte_in;
  assign ofree  = !ovalid_q || out_if.ready;
  assign in_if.ready = (state_q == ST_IDLE) && !ovalid_q;
  assign dstart = in_if.valid && in_if.ready && hpos_q == 3'd3;
  assign kw     = kw_text(kw_q);
  assign kwch   = kw[idx_q*8 +: 8];
  assign kwend  = (idx_q == 4'(KwMaxLen - 1)) || (kw[(idx_q+4'd1)*8 +: 8] == 8'h00);

  // output register loads from the sequencer or from a plain content byte
  assign oload = (state_q == ST_NUM || state_q == ST_KW || state_q == ST_LE ||
                  state_q == ST_SE) ? ofree
               : (state_q == ST_IDLE && in_if.valid && in_if.ready && hpos_q >= 3'd4 &&
                  skip_q == 3'd0 && b != NumMarkA && b != NumMarkB &&
                  !(b == NewlineTok && left_q == 16'd1) && b < KwFirst);

  bpd_digits u_digits (
    .clk_i, .rst_ni, .start_i(dstart), .value_i(line_q),
    .done_o(ddone), .digits_o(digits)
  );

  // index of the first non-zero digit, or of the last digit if all are zero
  always_comb begin
    if (digits[19:16] != 0) nd = 4'd0;
    else if (digits[15:12] != 0) nd = 4'd1;
    else if (digits[11:8] != 0) nd = 4'd2;
    else if (digits[7:4] != 0) nd = 4'd3;
    else nd = 4'd4;
  end

  function automatic out_item_t mk(input logic [7:0] c, input logic h, input logic le,
                                   input logic se, input logic tr, input logic rl);
    out_item_t r;
    r.char_out = c; r.has_char = h; r.line_end = le;
    r.stream_end = se; r.truncated = tr; r.run_last = rl;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      hpos_q   <= '0;
      line_q   <= '0;
      left_q   <= '0;
      skip_q   <= '0;
      space_q  <= 1'b0;
      last_q   <= 1'b0;
      idx_q    <= '0;
      lead_q   <= 1'b0;
      kw_q     <= '0;
      ovalid_q <= 1'b0;
      odata_q  <= '0;
    end else begin
      ovalid_q <= oload || (ovalid_q && !out_if.ready);
      unique case (state_q)
        ST_IDLE: begin
          if (in_if.valid && in_if.ready) begin
            last_q <= in_if.data.last_in;
            unique case (hpos_q)
              3'd0: begin
                line_q <= {b, 8'h00}; hpos_q <= 3'd1;
                if (in_if.data.last_in) state_q <= ST_SE;
              end
              3'd1: begin
                line_q <= {line_q[15:8], b}; hpos_q <= 3'd2;
                if (in_if.data.last_in) state_q <= ST_SE;
              end
              3'd2: begin
                left_q <= {8'h00, b}; hpos_q <= 3'd3;
                if (in_if.data.last_in) state_q <= ST_SE;
              end
              3'd3: begin
                left_q <= {b, left_q[7:0]}; skip_q <= '0;
                hpos_q <= ({b, left_q[7:0]} == 16'd0) ? 3'd0 : 3'd4;
                state_q <= ST_DIGITS;
              end
              default: begin
                left_q <= left_q - ((left_q != 0) ? 16'd1 : 16'd0);
                if (left_q <= 16'd1) begin
                  hpos_q <= 3'd0;
                end
                if (skip_q != 0) begin
                  skip_q <= (left_q <= 16'd1) ? 3'd0 : skip_q - 3'd1;
                  state_q <= (left_q <= 16'd1) ? ST_LE
                           : (in_if.data.last_in ? ST_SE : ST_IDLE);
                end else if (b == NumMarkA || b == NumMarkB) begin
                  skip_q <= (left_q <= 16'd1) ? 3'd0 : 3'd5;
                  state_q <= (left_q <= 16'd1) ? ST_LE
                           : (in_if.data.last_in ? ST_SE : ST_IDLE);
                end else if (b == NewlineTok && left_q == 16'd1) begin
                  state_q <= ST_LE;
                end else if (b >= KwFirst) begin
                  kw_q   <= 7'(b - KwFirst);
                  idx_q  <= '0;
                  lead_q <= !space_q;
                  state_q <= ST_KW;
                end else begin
                  odata_q  <= mk((b >= 8'h20 && b <= 8'h7E) ? b : DotChar, 1'b1, 1'b0,
                                 1'b0, 1'b0, (left_q > 16'd1) && !in_if.data.last_in);
                  space_q  <= (b == SpaceChar);
                  state_q  <= (left_q <= 16'd1) ? ST_LE
                            : (in_if.data.last_in ? ST_SE : ST_IDLE);
                end
              end
            endcase
          end
        end
        ST_DIGITS: begin
          if (ddone) begin
            idx_q   <= nd;
            state_q <= ST_NUM;
          end
        end
        ST_NUM: begin
          if (ofree) begin
            if (idx_q == 4'd5) begin
              odata_q <= mk(SpaceChar, 1'b1, 1'b0, 1'b0, 1'b0,
                            (hpos_q != 3'd0) && !last_q);
              space_q <= 1'b1;
              state_q <= (hpos_q == 3'd0) ? ST_LE : (last_q ? ST_SE : ST_IDLE);
            end else begin
              odata_q <= mk(ZeroChar | {4'h0, digits[19 - 4*idx_q[2:0] -: 4]},
                            1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
              space_q <= 1'b0;
              idx_q   <= idx_q + 4'd1;
            end
          end
        end
        ST_KW: begin
          if (ofree) begin
            if (lead_q) begin
              odata_q <= mk(SpaceChar, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
              space_q <= 1'b1;
              lead_q  <= 1'b0;
            end else begin
              odata_q <= mk(kwch, 1'b1, 1'b0, 1'b0, 1'b0,
                            kwend && (hpos_q != 3'd0) && !last_q);
              space_q <= (kwch == SpaceChar);
              idx_q   <= idx_q + 4'd1;
              if (kwend) begin
                state_q <= (hpos_q == 3'd0) ? ST_LE : (last_q ? ST_SE : ST_IDLE);
              end
            end
          end
        end
        ST_LE: begin
          if (ofree) begin
            odata_q  <= mk(8'h00, 1'b0, 1'b1, 1'b0, 1'b0, !last_q);
            state_q  <= last_q ? ST_SE : ST_IDLE;
          end
        end
        ST_SE: begin
          if (ofree) begin
            odata_q  <= mk(8'h00, 1'b0, 1'b0, 1'b1, hpos_q != 3'd0, 1'b1);
            state_q  <= ST_IDLE;
            hpos_q   <= '0;
            line_q   <= '0;
            left_q   <= '0;
            skip_q   <= '0;
            space_q  <= 1'b0;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_if.valid = ovalid_q;
  assign out_if.data  = odata_q;

  `BPD_ASSERT_IMP(a_no_accept_busy, state_q != ST_IDLE, !in_if.ready)
  `BPD_ASSERT_IMP(a_se_marks_last, out_if.valid && out_if.data.stream_end,
                  out_if.data.run_last && !out_if.data.has_char)
  `BPD_ASSERT_IMP(a_marker_no_char, out_if.valid && out_if.data.line_end,
                  !out_if.data.has_char && out_if.data.char_out == 8'h00)
  `BPD_ASSERT_NEXT(a_hold_stall, out_if.valid && !out_if.ready,
                   out_if.valid && $stable(out_if.data))

endmodule
`default_nettype wire
